// ===== rtl/nearest_neighbor_tour_top_assert.svh =====
// Assertion macros shared by the nearest neighbor tour RTL.
`ifndef NEAREST_NEIGHBOR_TOUR_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_TOUR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NNT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define NNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NNT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define NNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/nnt_pkg.sv =====
// Types and constants shared by the nearest neighbor tour modules.
`timescale 1ns / 1ps
`default_nettype none
package nnt_pkg;

	localparam int NNT_MAX_POINTS = 1024;
	localparam int NNT_COORD_BITS = 16;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_NEXT  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_POINT   = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_REFUSED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_LATCH,
		S_SCAN,
		S_DRAIN,
		S_RESULT
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] point_x;
		logic [15:0] point_y;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [9:0]  point_index;
		logic [15:0] out_x;
		logic [15:0] out_y;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic take_in;
		logic latch_cur;
		logic scan;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic no_point;
		logic first;
		logic scan_last;
		logic pipe_busy;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/nnt_ctrl.sv =====
// Controller state machine that sequences load, request and clear transactions.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_tour_top_assert.svh"
module nnt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nnt_pkg::dp_stat_t stat,
	output nnt_pkg::dp_cmd_t  cmd
);
	import nnt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.op == OP_NEXT && !stat.no_point) state_d = S_LATCH;
				else state_d = S_RESULT;
			end
			S_LATCH: begin
				// The first tour point is always point 0; no search is needed.
				if (stat.first) state_d = S_RESULT;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) state_d = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take_in = in_valid;
			end
			S_LATCH: begin
				cmd.latch_cur = 1'b1;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_RESULT: begin
				cmd.commit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`NNT_ASSERT_NEXT(a_commit_returns_idle, clk, arst_n, cmd.commit, state_q == S_IDLE, "commit did not return to idle")
	`NNT_ASSERT_NEXT(a_empty_skips_search, clk, arst_n, state_q == S_DECIDE && stat.no_point, state_q == S_RESULT, "request with no point left started a search")

endmodule
`default_nettype wire

// ===== rtl/nnt_dp.sv =====
// Datapath: point store, visited map, distance pipeline, tour state and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_neighbor_tour_top_assert.svh"
module nnt_dp #(
	parameter int MAX_POINTS = nnt_pkg::NNT_MAX_POINTS,
	parameter int COORD_BITS = nnt_pkg::NNT_COORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nnt_pkg::in_item_t  in_data,
	input  nnt_pkg::dp_cmd_t   cmd,
	output nnt_pkg::dp_stat_t  stat,
	output logic               out_valid,
	input  logic               out_ready,
	output nnt_pkg::out_item_t out_data
);
	import nnt_pkg::*;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int DIST_W = 2 * COORD_BITS + 1;

	// Latched transaction.
	op_t                   op_q;
	logic [COORD_BITS-1:0] px_q;
	logic [COORD_BITS-1:0] py_q;
	logic [COORD_BITS+15:0] px_ext;
	logic [COORD_BITS+15:0] py_ext;

	// Tour state.
	logic [CNT_W-1:0] pc_q;
	logic [CNT_W-1:0] emitted_q;
	logic [IDX_W-1:0] cur_q;

	// Stores.
	logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
	logic [COORD_BITS-1:0] y_mem [MAX_POINTS];
	logic                  vis_mem [MAX_POINTS];

	logic                  st_we;
	logic                  vis_we;
	logic [IDX_W-1:0]      vis_wa;
	logic                  vis_wd;
	logic [IDX_W-1:0]      rd_addr;

	// Scan pipeline.
	logic [CNT_W-1:0]      scan_cnt_q;
	logic                  v_s1;
	logic                  vis_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic                  v_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic [COORD_BITS-1:0] x_s2;
	logic [COORD_BITS-1:0] y_s2;
	logic [COORD_BITS-1:0] dx_s2;
	logic [COORD_BITS-1:0] dy_s2;
	logic                  v_s3;
	logic [IDX_W-1:0]      idx_s3;
	logic [COORD_BITS-1:0] x_s3;
	logic [COORD_BITS-1:0] y_s3;
	logic [2*COORD_BITS-1:0] sqx_s3;
	logic [2*COORD_BITS-1:0] sqy_s3;
	logic [DIST_W-1:0]     d_s3;
	logic                  better;

	// Current point and best candidate.
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic [COORD_BITS-1:0] best_x_q;
	logic [COORD_BITS-1:0] best_y_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [DIST_W-1:0]     best_d_q;
	logic                  found_q;

	// Result.
	logic                   refused;
	out_item_t              res_d;
	out_item_t              out_q;
	logic                   out_valid_q;
	logic                   point_given;
	logic [IDX_W+9:0]       idx_ext;
	logic [COORD_BITS+15:0] bx_ext;
	logic [COORD_BITS+15:0] by_ext;

	assign px_ext = {{COORD_BITS{1'b0}}, in_data.point_x};
	assign py_ext = {{COORD_BITS{1'b0}}, in_data.point_y};

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			op_q <= in_data.op;
			px_q <= px_ext[COORD_BITS-1:0];
			py_q <= py_ext[COORD_BITS-1:0];
		end
	end

	// Status toward the controller.
	assign refused = (pc_q == CNT_W'(MAX_POINTS)) || (emitted_q != '0);

	always_comb begin
		stat.op        = op_q;
		stat.no_point  = (emitted_q >= pc_q);
		stat.first     = (emitted_q == '0);
		stat.scan_last = ((scan_cnt_q + CNT_W'(1)) == pc_q);
		stat.pipe_busy = v_s1 | v_s2 | v_s3;
		stat.out_free  = !out_valid_q || out_ready;
	end

	// Store ports. A load clears the visited bit of the entry it fills, so every
	// entry below the point count holds a valid visited bit without a sweep.
	assign st_we   = cmd.commit && (op_q == OP_LOAD) && !refused;
	assign point_given = (res_d.status == ST_POINT);
	assign vis_we  = st_we || (cmd.commit && point_given);
	assign vis_wa  = st_we ? pc_q[IDX_W-1:0] : best_idx_q;
	assign vis_wd  = !st_we;
	assign rd_addr = cmd.scan ? scan_cnt_q[IDX_W-1:0] : cur_q;

	always_ff @(posedge clk) begin
		if (st_we) begin
			x_mem[pc_q[IDX_W-1:0]] <= px_q;
			y_mem[pc_q[IDX_W-1:0]] <= py_q;
		end
		x_s1 <= x_mem[rd_addr];
		y_s1 <= y_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		vis_s1 <= vis_mem[rd_addr];
		idx_s1 <= rd_addr;
	end

	// Scan address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
		end else if (cmd.latch_cur) begin
			scan_cnt_q <= '0;
		end else if (cmd.scan) begin
			scan_cnt_q <= scan_cnt_q + CNT_W'(1);
		end
	end

	// Pipeline valid bits; visited points drop out after the read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan;
			v_s2 <= v_s1 && !vis_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		dx_s2  <= (x_s1 >= cx_q) ? (x_s1 - cx_q) : (cx_q - x_s1);
		dy_s2  <= (y_s1 >= cy_q) ? (y_s1 - cy_q) : (cy_q - y_s1);
		idx_s3 <= idx_s2;
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
	end

	assign d_s3   = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	// Strict less-than keeps the lowest index on equal distances.
	assign better = v_s3 && (!found_q || (d_s3 < best_d_q));

	always_ff @(posedge clk) begin
		if (cmd.latch_cur) begin
			cx_q       <= x_s1;
			cy_q       <= y_s1;
			best_x_q   <= x_s1;
			best_y_q   <= y_s1;
			best_idx_q <= cur_q;
		end else if (better) begin
			best_x_q   <= x_s3;
			best_y_q   <= y_s3;
			best_idx_q <= idx_s3;
			best_d_q   <= d_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.latch_cur) begin
			found_q <= stat.first;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	// Result of the latched transaction.
	assign idx_ext = {10'd0, best_idx_q};
	assign bx_ext  = {16'd0, best_x_q};
	assign by_ext  = {16'd0, best_y_q};

	always_comb begin
		res_d = '0;
		unique case (op_q)
			OP_LOAD: begin
				res_d.status = refused ? ST_REFUSED : ST_DONE;
			end
			OP_NEXT: begin
				if (stat.no_point || !found_q) begin
					res_d.status = ST_EMPTY;
				end else begin
					res_d.status      = ST_POINT;
					res_d.point_index = idx_ext[9:0];
					res_d.out_x       = bx_ext[15:0];
					res_d.out_y       = by_ext[15:0];
					res_d.last        = ((emitted_q + CNT_W'(1)) == pc_q);
				end
			end
			default: begin
				res_d.status = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			emitted_q <= '0;
			cur_q     <= '0;
		end else if (cmd.commit) begin
			unique case (op_q)
				OP_LOAD: begin
					if (!refused) pc_q <= pc_q + CNT_W'(1);
				end
				OP_NEXT: begin
					if (point_given) begin
						emitted_q <= emitted_q + CNT_W'(1);
						cur_q     <= best_idx_q;
					end
				end
				OP_CLEAR: begin
					pc_q      <= '0;
					emitted_q <= '0;
					cur_q     <= '0;
				end
				default: begin
					pc_q <= pc_q;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`NNT_ASSERT_IMPLY(a_commit_after_drain, clk, arst_n, cmd.commit, !(v_s1 || v_s2 || v_s3), "result committed while the scan pipeline was busy")
	`NNT_ASSERT_NEXT(a_point_advances_tour, clk, arst_n, cmd.commit && point_given, emitted_q == $past(emitted_q) + CNT_W'(1), "tour point given without advancing the count")

endmodule
`default_nettype wire

// ===== rtl/nearest_neighbor_tour_top.sv =====
// Top level of the nearest neighbor tour block.
// Usage:
// Input channel in_valid/in_ready/in_data carries one transaction per item: a load
// appends a point, a request returns the next tour point, a clear empties the store.
// Output channel out_valid/out_ready/out_data returns exactly one result per input.
// A load, a clear, an unused code or a request with no point left goes from the
// decide state straight to the result state. The first request of a tour returns
// point 0 without a search. Each later request scans all N stored points through
// the single read port of the point store, one point per cycle, then drains a
// three-stage distance pipeline before its result is committed.
// Only one transaction is in flight; in_ready is high whenever the controller idles,
// even while a finished result waits in the output register, so a new transaction
// is accepted at the earliest in the cycle after the previous result is committed.
// When the receiver stalls, the result holds in the output register and the next
// transaction waits at its final step until the register frees.
// Reset empties the store, clears the tour and drops any pending result; the store
// itself needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbor_tour_top #(
	parameter int MAX_POINTS = nnt_pkg::NNT_MAX_POINTS,
	parameter int COORD_BITS = nnt_pkg::NNT_COORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nnt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output nnt_pkg::out_item_t out_data
);
	import nnt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	nnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	nnt_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== dv/nearest_neighbor_tour_checker.sv =====
// Checker for the nearest neighbor tour block: predicts each result and compares it.
`timescale 1ns / 1ps
module nearest_neighbor_tour_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  nnt_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  nnt_pkg::out_item_t out_data,
	output int                 pending,
	output int                 fail_count
);
	import nnt_pkg::*;

	logic [15:0] x_mem [NNT_MAX_POINTS];
	logic [15:0] y_mem [NNT_MAX_POINTS];
	bit          visited [NNT_MAX_POINTS];
	int          stored;
	int          given;
	int          here;
	out_item_t   tour_results [$];

	function automatic out_item_t advance_tour(in_item_t it);
		out_item_t   res;
		logic [33:0] dx;
		logic [33:0] dy;
		logic [33:0] sq_dist;
		logic [33:0] best;
		int          pick;
		int          i;
		res = '0;
		res.status = ST_DONE;
		pick = -1;
		best = '0;
		case (it.op)
			OP_LOAD: begin
				if (stored >= NNT_MAX_POINTS || given != 0) begin
					res.status = ST_REFUSED;
				end else begin
					x_mem[stored] = it.point_x;
					y_mem[stored] = it.point_y;
					stored++;
				end
			end
			OP_NEXT: begin
				if (given >= stored) begin
					res.status = ST_EMPTY;
				end else if (given == 0) begin
					pick = 0;
				end else begin
					// Strict less-than keeps the lowest index among equal distances.
					for (i = 0; i < stored; i++) begin
						if (!visited[i]) begin
							dx = (x_mem[i] >= x_mem[here]) ? x_mem[i] - x_mem[here]
								: x_mem[here] - x_mem[i];
							dy = (y_mem[i] >= y_mem[here]) ? y_mem[i] - y_mem[here]
								: y_mem[here] - y_mem[i];
							sq_dist = dx * dx + dy * dy;
							if (pick < 0 || sq_dist < best) begin
								pick = i;
								best = sq_dist;
							end
						end
					end
					if (pick < 0) begin
						res.status = ST_EMPTY;
					end
				end
				if (pick >= 0) begin
					visited[pick] = 1'b1;
					here = pick;
					given++;
					res.status = ST_POINT;
					res.point_index = 10'(pick);
					res.out_x = x_mem[pick];
					res.out_y = y_mem[pick];
					res.last = (given == stored);
				end
			end
			OP_CLEAR: begin
				foreach (visited[k]) begin
					visited[k] = 1'b0;
				end
				stored = 0;
				given = 0;
				here = 0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			tour_results.delete();
			foreach (visited[k]) begin
				visited[k] = 1'b0;
			end
			stored = 0;
			given = 0;
			here = 0;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				tour_results = {tour_results, advance_tour(in_data)};
			end
			if (out_valid && out_ready) begin
				if (tour_results.size() == 0) begin
					$error("result transaction with no request outstanding: %p", out_data);
					fail_count++;
				end else begin
					want = tour_results.pop_front();
					check_field("status", want.status, out_data.status);
					check_field("point_index", want.point_index, out_data.point_index);
					check_field("out_x", want.out_x, out_data.out_x);
					check_field("out_y", want.out_y, out_data.out_y);
					check_field("last", want.last, out_data.last);
				end
			end
			pending <= tour_results.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the nearest neighbor tour testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
	import nnt_pkg::*;

	localparam int  CYCLE_LIMIT  = 1000000;
	localparam int  RANDOM_ITEMS = 550;
	localparam int  SETTLE       = 1100;
	localparam op_t OP_UNUSED    = op_t'(2'd3);

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic [15:0] ready_pattern;
	int          burst_left;
	int          items_sent;
	int          cycles;
	int          pending;
	int          fail_count;

	nearest_neighbor_tour_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	nearest_neighbor_tour_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The receiver follows a rotating ready pattern that is swapped now and then;
	// an all-ones pattern gives stretches without stalls.
	always @(posedge clk) begin
		if ($urandom_range(0, 149) == 0) begin
			ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
				: (16'($urandom) | 16'h0001);
		end else begin
			ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
		end
		out_ready <= ready_pattern[0];
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] pick_coord(int mode);
		case (mode)
			0: return 16'($urandom_range(0, 7));
			1: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Valid stays high across a burst; a new burst starts after a random gap.
	task automatic send_item(op_t op, logic [15:0] x, logic [15:0] y);
		in_item_t it;
		it.op = op;
		it.point_x = x;
		it.point_y = y;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		items_sent++;
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_noise(int mode);
		send_item(op_t'($urandom_range(0, 3)), pick_coord(mode), pick_coord(mode));
	endtask

	task automatic run_tour(int n, int mode);
		int asks;
		if ($urandom_range(0, 4) != 0) begin
			send_item(OP_CLEAR, pick_coord(2), pick_coord(2));
		end
		repeat (n) send_item(OP_LOAD, pick_coord(mode), pick_coord(mode));
		asks = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : n + $urandom_range(0, 2);
		repeat (asks) begin
			if ($urandom_range(0, 11) == 0) begin
				send_noise(mode);
			end
			send_item(OP_NEXT, pick_coord(2), pick_coord(2));
		end
	endtask

	initial begin
		int start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		ready_pattern = 16'hFFFF;
		cycles = 0;
		burst_left = 0;
		items_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Requests and odd codes on an empty store.
		send_item(OP_NEXT, 16'h0000, 16'h0000);
		send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
		send_item(OP_CLEAR, 16'h0000, 16'h0000);
		// The two duplicates at the origin and the mirrored pair tie on distance.
		send_item(OP_LOAD, 16'h8000, 16'h8000);
		send_item(OP_LOAD, 16'h0000, 16'h0000);
		send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
		send_item(OP_LOAD, 16'h5555, 16'hAAAA);
		send_item(OP_LOAD, 16'hAAAA, 16'h5555);
		send_item(OP_LOAD, 16'h0000, 16'h0000);
		send_item(OP_NEXT, 16'hFFFF, 16'hFFFF);
		send_item(OP_LOAD, 16'h1234, 16'h4321);
		send_item(OP_NEXT, 16'h0000, 16'h0000);
		send_item(OP_UNUSED, 16'h0000, 16'h0000);
		repeat (5) send_item(OP_NEXT, 16'h0000, 16'h0000);
		send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF);
		send_item(OP_LOAD, 16'hFFFF, 16'h0000);
		send_item(OP_NEXT, 16'h0000, 16'h0000);
		send_item(OP_NEXT, 16'h0000, 16'h0000);
		send_item(OP_CLEAR, 16'h0000, 16'h0000);
		wait_all_results();

		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) != 0) begin
				run_tour(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
					: $urandom_range(1, 16), $urandom_range(0, 2));
			end else begin
				repeat ($urandom_range(1, 6)) send_noise($urandom_range(0, 2));
			end
			if ($urandom_range(0, 7) == 0) begin
				wait_all_results();
			end
		end

		wait_all_results();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
